[rtl/cnst_pkg.sv]
package cnst_pkg;

  localparam int unsigned SLOTS = 8;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SIDX_W = 3;
  localparam logic [DATA_W-1:0] TIMEOUT_RESET = 32'd50000;

  typedef enum logic {
    CMD_CHALLENGE = 1'b0,
    CMD_VERIFY    = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ISSUED   = 3'd0,
    STAT_ACCEPTED = 3'd1,
    STAT_NO_SLOT  = 3'd2,
    STAT_MISMATCH = 3'd3,
    STAT_EXPIRED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

  function automatic logic [SIDX_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SIDX_W-1:0] ext;
    ext = {{SIDX_W{1'b0}}, idx};
    return ext[SIDX_W-1:0];
  endfunction

endpackage

[rtl/cnst_req_if.sv]
interface cnst_req_if;
  logic                          valid;
  logic                          ready;
  cnst_pkg::cmd_e                command;
  logic [cnst_pkg::DATA_W-1:0]   client_ip;
  logic [cnst_pkg::DATA_W-1:0]   nonce_value;
  logic [cnst_pkg::DATA_W-1:0]   now_ms;

  modport source (output valid, command, client_ip, nonce_value, now_ms, input ready);
  modport sink (input valid, command, client_ip, nonce_value, now_ms, output ready);
endinterface

[rtl/cnst_rsp_if.sv]
interface cnst_rsp_if;
  logic                          valid;
  logic                          ready;
  cnst_pkg::status_e             status;
  logic [cnst_pkg::SIDX_W-1:0]   slot_index;
  logic [cnst_pkg::DATA_W-1:0]   issued_nonce;

  modport source (output valid, status, slot_index, issued_nonce, input ready);
  modport sink (input valid, status, slot_index, issued_nonce, output ready);
endinterface

[rtl/challenge_nonce_slot_table.sv]
// channel   dir  handshake      payload
// req_i     in   valid/ready    command, client_ip, nonce_value, now_ms
// rsp_o     out  valid/ready    status, slot_index, issued_nonce
// cfg       in   cfg_we_i       cfg_wdata_i -> timeout_ms
//
// One request at a time. After a request transfer the slot scan reads one slot per
// cycle through all SLOTS slots, a commit state then updates the table, and the
// response is valid from the state after the commit; the next request is taken in
// the cycle after the response transfer.
// Reset marks every slot free and loads timeout_ms with 50000.
// A stalled response holds the block; no request is taken until it transfers.
module challenge_nonce_slot_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cnst_pkg::DATA_W-1:0] cfg_wdata_i,
  cnst_req_if.sink                    req_i,
  cnst_rsp_if.source                  rsp_o
);

  cnst_pkg::ctrl_cmd_t ctrl_cmd;
  cnst_pkg::dp_stat_t  dp_stat;

  cnst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  cnst_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_i      (req_i.command),
    .client_ip_i    (req_i.client_ip),
    .nonce_value_i  (req_i.nonce_value),
    .now_ms_i       (req_i.now_ms),
    .status_o       (rsp_o.status),
    .slot_index_o   (rsp_o.slot_index),
    .issued_nonce_o (rsp_o.issued_nonce)
  );

endmodule

[rtl/cnst_ctrl.sv]
module cnst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  cnst_pkg::dp_stat_t  stat_i,
  output cnst_pkg::ctrl_cmd_t cmd_o
);

  cnst_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cnst_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      cnst_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = cnst_pkg::S_SCAN;
        end
      end
      cnst_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = cnst_pkg::S_COMMIT;
        end
      end
      cnst_pkg::S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = cnst_pkg::S_RESP;
      end
      cnst_pkg::S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = cnst_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cnst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/cnst_datapath.sv]
module cnst_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cnst_pkg::ctrl_cmd_t           cmd_i,
  output cnst_pkg::dp_stat_t            stat_o,
  input  logic                          cfg_we_i,
  input  logic [cnst_pkg::DATA_W-1:0]   cfg_wdata_i,
  input  cnst_pkg::cmd_e                command_i,
  input  logic [cnst_pkg::DATA_W-1:0]   client_ip_i,
  input  logic [cnst_pkg::DATA_W-1:0]   nonce_value_i,
  input  logic [cnst_pkg::DATA_W-1:0]   now_ms_i,
  output cnst_pkg::status_e             status_o,
  output logic [cnst_pkg::SIDX_W-1:0]   slot_index_o,
  output logic [cnst_pkg::DATA_W-1:0]   issued_nonce_o
);

  localparam int unsigned IW = cnst_pkg::IDX_W;
  localparam int unsigned DW = cnst_pkg::DATA_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(cnst_pkg::SLOTS - 1);

  logic [DW-1:0] addr_mem_q  [cnst_pkg::SLOTS];
  logic [DW-1:0] nonce_mem_q [cnst_pkg::SLOTS];
  logic [DW-1:0] time_mem_q  [cnst_pkg::SLOTS];
  logic [cnst_pkg::SLOTS-1:0] active_q;

  logic [DW-1:0] timeout_q;

  cnst_pkg::cmd_e cmd_q;
  logic [DW-1:0] ip_q, nonce_q, now_q;
  logic [IW-1:0] cnt_q;

  logic          hit_q, free_q;
  logic [IW-1:0] hit_idx_q, free_idx_q, min_idx_q;
  logic [DW-1:0] hit_nonce_q, hit_time_q, min_time_q;

  cnst_pkg::status_e           status_q;
  logic [cnst_pkg::SIDX_W-1:0] slot_q;
  logic [DW-1:0]               issued_q;

  logic          rd_active;
  logic [DW-1:0] rd_addr, rd_nonce, rd_time;
  logic          rd_match;
  logic [IW-1:0] tgt_idx;
  logic [DW-1:0] age;
  logic          do_write, do_clear;

  assign rd_active = active_q[cnt_q];
  assign rd_addr   = addr_mem_q[cnt_q];
  assign rd_nonce  = nonce_mem_q[cnt_q];
  assign rd_time   = time_mem_q[cnt_q];
  assign rd_match  = rd_active && (rd_addr == ip_q);

  assign stat_o.scan_last = (cnt_q == LAST_IDX);

  assign tgt_idx  = hit_q ? hit_idx_q : (free_q ? free_idx_q : min_idx_q);
  assign age      = now_q - hit_time_q;
  assign do_write = cmd_i.commit && (cmd_q == cnst_pkg::CMD_CHALLENGE);
  assign do_clear = cmd_i.commit && (cmd_q == cnst_pkg::CMD_VERIFY) && hit_q
                    && (hit_nonce_q == nonce_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      timeout_q <= cnst_pkg::TIMEOUT_RESET;
      cnt_q     <= '0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        if (!stat_o.scan_last) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (rd_match) begin
          hit_q <= 1'b1;
        end
        if (!rd_active) begin
          free_q <= 1'b1;
        end
      end
      if (do_write) begin
        active_q[tgt_idx] <= 1'b1;
      end
      if (do_clear) begin
        active_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= command_i;
      ip_q    <= client_ip_i;
      nonce_q <= nonce_value_i;
      now_q   <= now_ms_i;
    end
    if (cmd_i.scan) begin
      if (rd_match && !hit_q) begin
        hit_idx_q   <= cnt_q;
        hit_nonce_q <= rd_nonce;
        hit_time_q  <= rd_time;
      end
      if (!rd_active && !free_q) begin
        free_idx_q <= cnt_q;
      end
      if ((cnt_q == '0) || (rd_time < min_time_q)) begin
        min_time_q <= rd_time;
        min_idx_q  <= cnt_q;
      end
    end
    if (do_write) begin
      addr_mem_q[tgt_idx]  <= ip_q;
      nonce_mem_q[tgt_idx] <= nonce_q;
      time_mem_q[tgt_idx]  <= now_q;
    end
    if (cmd_i.commit) begin
      if (cmd_q == cnst_pkg::CMD_CHALLENGE) begin
        status_q <= cnst_pkg::STAT_ISSUED;
        slot_q   <= cnst_pkg::slot_field(tgt_idx);
        issued_q <= nonce_q;
      end else begin
        issued_q <= '0;
        if (!hit_q) begin
          status_q <= cnst_pkg::STAT_NO_SLOT;
          slot_q   <= '0;
        end else begin
          slot_q <= cnst_pkg::slot_field(hit_idx_q);
          if (hit_nonce_q != nonce_q) begin
            status_q <= cnst_pkg::STAT_MISMATCH;
          end else if (age > timeout_q) begin
            status_q <= cnst_pkg::STAT_EXPIRED;
          end else begin
            status_q <= cnst_pkg::STAT_ACCEPTED;
          end
        end
      end
    end
  end

  assign status_o       = status_q;
  assign slot_index_o   = slot_q;
  assign issued_nonce_o = issued_q;

endmodule

[verif/slot_table_checker.sv]
module slot_table_checker
  import cnst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [DATA_W-1:0]   cfg_wdata_i,
  cnst_req_if                 req_i,
  cnst_rsp_if                 rsp_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct packed {
    status_e             status;
    logic [SIDX_W-1:0]   slot;
    logic [DATA_W-1:0]   issued;
  } reply_t;

  reply_t              replies_due[$];
  logic [DATA_W-1:0]   timeout_q;
  logic [DATA_W-1:0]   entry_ip    [SLOTS];
  logic [DATA_W-1:0]   entry_nonce [SLOTS];
  logic [DATA_W-1:0]   entry_stamp [SLOTS];
  logic                entry_live  [SLOTS];

  function automatic int find_client(logic [DATA_W-1:0] ip);
    int hit;
    hit = -1;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (entry_live[k] && entry_ip[k] == ip) hit = k;
    end
    return hit;
  endfunction

  function automatic reply_t serve_request(cmd_e cmd, logic [DATA_W-1:0] ip,
                                           logic [DATA_W-1:0] nonce,
                                           logic [DATA_W-1:0] now);
    reply_t           r;
    int               hit;
    logic [DATA_W-1:0] age;
    r.status = STAT_ISSUED;
    r.slot   = '0;
    r.issued = '0;
    hit = find_client(ip);
    if (cmd == CMD_CHALLENGE) begin
      if (hit < 0) begin
        for (int k = SLOTS - 1; k >= 0; k--) begin
          if (!entry_live[k]) hit = k;
        end
      end
      // full table: evict the oldest stamp, lowest index on ties
      if (hit < 0) begin
        hit = 0;
        for (int k = 1; k < SLOTS; k++) begin
          if (entry_stamp[k] < entry_stamp[hit]) hit = k;
        end
      end
      entry_ip[hit]    = ip;
      entry_nonce[hit] = nonce;
      entry_stamp[hit] = now;
      entry_live[hit]  = 1'b1;
      r.slot   = SIDX_W'(hit);
      r.issued = nonce;
    end else if (hit < 0) begin
      r.status = STAT_NO_SLOT;
    end else begin
      r.slot = SIDX_W'(hit);
      if (entry_nonce[hit] != nonce) begin
        r.status = STAT_MISMATCH;
      end else begin
        age = now - entry_stamp[hit];
        r.status = (age > timeout_q) ? STAT_EXPIRED : STAT_ACCEPTED;
        entry_ip[hit]    = '0;
        entry_nonce[hit] = '0;
        entry_stamp[hit] = '0;
        entry_live[hit]  = 1'b0;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      timeout_q = TIMEOUT_RESET;
      for (int k = 0; k < SLOTS; k++) begin
        entry_ip[k]    = '0;
        entry_nonce[k] = '0;
        entry_stamp[k] = '0;
        entry_live[k]  = 1'b0;
      end
      replies_due.delete();
      mismatches_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply status %0d slot %0d nonce %h", $time,
                   rsp_i.status, rsp_i.slot_index, rsp_i.issued_nonce);
          mismatches_o++;
        end else begin
          want = replies_due.pop_front();
          if (rsp_i.status !== want.status || rsp_i.slot_index !== want.slot ||
              rsp_i.issued_nonce !== want.issued) begin
            $display("%0t: reply mismatch: expected status %0d slot %0d nonce %h, got status %0d slot %0d nonce %h",
                     $time, want.status, want.slot, want.issued,
                     rsp_i.status, rsp_i.slot_index, rsp_i.issued_nonce);
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) timeout_q = cfg_wdata_i;
      if (req_i.valid && req_i.ready) begin
        replies_due.push_back(serve_request(req_i.command, req_i.client_ip,
                                            req_i.nonce_value, req_i.now_ms));
      end
    end
    pending_o = replies_due.size();
  end

endmodule

[verif/tb.sv]
module tb;
  import cnst_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL = 12;
  localparam int SETTLE = SLOTS + 3;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [DATA_W-1:0] cfg_wdata_i;
  int                mismatches;
  int                pending;
  int                cycle_count = 0;
  int                src_idle_pct;
  int                snk_idle_pct;

  logic [DATA_W-1:0] clock_ms;
  logic [DATA_W-1:0] pool_ip    [POOL];
  logic [DATA_W-1:0] pool_nonce [POOL];

  cnst_req_if req();
  cnst_rsp_if rsp();

  challenge_nonce_slot_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  slot_table_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (req),
    .rsp_i        (rsp),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("challenge_nonce_slot_table test failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    rsp.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  task automatic send_item(cmd_e cmd, logic [DATA_W-1:0] ip, logic [DATA_W-1:0] nonce,
                           logic [DATA_W-1:0] now);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid       <= 1'b1;
    req.command     <= cmd;
    req.client_ip   <= ip;
    req.nonce_value <= nonce;
    req.now_ms      <= now;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_timeout(logic [DATA_W-1:0] value);
    drain();
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_random(int count, int src_pct, int snk_pct, int unsigned span);
    int                r;
    int                k;
    logic [DATA_W-1:0] nonce;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 39) drain();
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, span);
      r = $urandom_range(0, 99);
      k = $urandom_range(0, POOL - 1);
      if (r < 40) begin
        nonce = $urandom;
        pool_nonce[k] = nonce;
        send_item(CMD_CHALLENGE, pool_ip[k], nonce, clock_ms);
      end else if (r < 75) begin
        send_item(CMD_VERIFY, pool_ip[k], pool_nonce[k], clock_ms);
      end else if (r < 88) begin
        nonce = pool_nonce[k] ^ (32'd1 << $urandom_range(0, 31));
        send_item(CMD_VERIFY, pool_ip[k], nonce, clock_ms);
      end else begin
        send_item(cmd_e'($urandom_range(0, 1)), $urandom, $urandom, clock_ms);
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    req.valid       = 1'b0;
    req.command     = CMD_CHALLENGE;
    req.client_ip   = '0;
    req.nonce_value = '0;
    req.now_ms      = '0;
    rsp.ready       = 1'b0;
    src_idle_pct    = 17;
    snk_idle_pct    = 80;
    clock_ms        = '0;
    for (int k = 0; k < POOL; k++) begin
      pool_ip[k]    = $urandom;
      pool_nonce[k] = $urandom;
    end
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(CMD_VERIFY, '0, '0, '0);
    send_item(CMD_CHALLENGE, '1, '1, '1);
    send_item(CMD_VERIFY, '1, '1, 32'd49999);
    send_item(CMD_CHALLENGE, '0, '0, '0);
    send_item(CMD_CHALLENGE, 32'hC0A8_0001, 32'h1234_5678, 32'd10);
    send_item(CMD_VERIFY, 32'hC0A8_0001, 32'h1234_5679, 32'd20);
    send_item(CMD_VERIFY, 32'hC0A8_0001, 32'h1234_5678, 32'd50011);
    send_item(CMD_VERIFY, 32'hC0A8_0001, 32'h1234_5678, 32'd50012);
    send_item(CMD_VERIFY, '0, '0, 32'd100);
    for (int k = 0; k < 8; k++) begin
      send_item(CMD_CHALLENGE, 32'h0A00_0000 + k, $urandom,
                (k == 1 || k == 2) ? 32'd300 : ((k == 0) ? 32'd700 : 32'd900));
    end
    send_item(CMD_CHALLENGE, 32'h0A00_0100, $urandom, 32'd1000);
    send_item(CMD_CHALLENGE, 32'h0A00_0005, 32'h5555_AAAA, 32'd1001);
    send_item(CMD_VERIFY, 32'h0A00_0005, 32'h5555_AAAA, 32'd51002);

    write_timeout('0);
    run_random(110, 17, 80, 2);
    write_timeout('1);
    run_random(110, 80, 17, 32'h4000_0000);
    write_timeout(32'd1000);
    run_random(115, 0, 0, 700);
    write_timeout(32'd300);
    run_random(115, 0, 0, 200);

    drain();
    repeat (2 * SETTLE) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("challenge_nonce_slot_table test passed");
    end else begin
      $display("challenge_nonce_slot_table test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cnst_pkg.sv
rtl/cnst_req_if.sv
rtl/cnst_rsp_if.sv
rtl/cnst_ctrl.sv
rtl/cnst_datapath.sv
rtl/challenge_nonce_slot_table.sv
verif/slot_table_checker.sv
verif/tb.sv
